>>> rtl/wrp_pkg.sv
// Shared types and constants of the weighted range partitioner.
`timescale 1ns / 1ps
`default_nettype none

package wrp_pkg;

  localparam int unsigned MAX_ITEMS_DEF   = 1024;
  localparam int unsigned WEIGHT_BITS_DEF = 16;

  localparam int unsigned BND_W = 11;  // boundary index port width
  localparam int unsigned REQ_W = 6;   // range request register width

  localparam logic [REQ_W-1:0] REQ_RESET = 6'd4;

  typedef enum logic [5:0] {
    WS_IDLE  = 6'b000001,
    WS_START = 6'b000010,
    WS_DEC   = 6'b000100,
    WS_ADD   = 6'b001000,
    WS_END   = 6'b010000,
    WS_PAD   = 6'b100000
  } wrp_walk_state_e;

  // one boundary request from the walker to the output register
  typedef struct packed {
    logic             valid;
    logic [BND_W-1:0] index;
    logic             last;
  } wrp_emit_t;

endpackage

`default_nettype wire

>>> rtl/wrp_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module wrp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/wrp_walk.sv
// Partition walk sequencer: scaled accumulate and compare over the stored weights.
`timescale 1ns / 1ps
`default_nettype none

module wrp_walk #(
  parameter int unsigned MAX_ITEMS   = wrp_pkg::MAX_ITEMS_DEF,
  parameter int unsigned WEIGHT_BITS = wrp_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          start_i,
  input  wire logic [$clog2(MAX_ITEMS+1)-1:0]                item_count_i,
  input  wire logic [WEIGHT_BITS+$clog2(MAX_ITEMS+1)-1:0]    total_i,
  input  wire logic [wrp_pkg::REQ_W-1:0]                     req_i,
  output logic                                               rd_en_o,
  output logic [((MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1)-1:0] rd_addr_o,
  input  wire logic [WEIGHT_BITS-1:0]                        rd_data_i,
  input  wire logic                                          slot_free_i,
  output wrp_pkg::wrp_emit_t                                 emit_o,
  output logic                                               done_o
);

  import wrp_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned TW = WEIGHT_BITS + CW;
  localparam int unsigned SW = TW + REQ_W;
  localparam int unsigned PW = WEIGHT_BITS + REQ_W;
  localparam int unsigned EW = REQ_W + 1;
  localparam int unsigned MW = (CW > REQ_W) ? CW : REQ_W;

  wrp_walk_state_e state_q, state_d;

  logic [CW-1:0]          pos_q, pos_d;
  logic [TW-1:0]          acc_q, acc_d;
  logic [SW-1:0]          scl_q, scl_d;    // acc * n
  logic [SW-1:0]          goal_q, goal_d;  // k * total
  logic [EW-1:0]          k_q, k_d;
  logic [REQ_W-1:0]       n_q, n_d;
  logic [EW-1:0]          em_q, em_d;      // results sent so far
  logic                   first_q, first_d;
  logic [PW-1:0]          prod_q, prod_d;
  logic [WEIGHT_BITS-1:0] w_q, w_d;
  logic [CW-1:0]          lastb_q, lastb_d;

  logic [MW-1:0] count_w, req_w;
  logic [CW-1:0] pos_inc;
  logic [EW-1:0] req_e, req_p1, k_inc;
  logic          below_goal, take, more;

  assign count_w = MW'(item_count_i);
  assign req_w   = MW'(req_i);
  assign pos_inc = pos_q + CW'(1);
  assign req_e   = EW'(req_i);
  assign req_p1  = req_e + EW'(1);
  assign k_inc   = k_q + EW'(1);

  // acc < floor(k*T/n)  <=>  (acc+1)*n <= k*T
  assign below_goal = ({1'b0, scl_q} + (SW+1)'(n_q)) <= {1'b0, goal_q};
  assign take       = first_q || below_goal || (rd_data_i == '0);
  assign more       = (acc_q < total_i) && (k_inc <= EW'(n_q));

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    acc_d     = acc_q;
    scl_d     = scl_q;
    goal_d    = goal_q;
    k_d       = k_q;
    n_d       = n_q;
    em_d      = em_q;
    first_d   = first_q;
    prod_d    = prod_q;
    w_d       = w_q;
    lastb_d   = lastb_q;
    rd_en_o   = 1'b0;
    rd_addr_o = pos_inc[AW-1:0];
    emit_o    = '0;
    done_o    = 1'b0;

    case (state_q)
      WS_IDLE: begin
        if (start_i) begin
          state_d = WS_START;
        end
      end
      WS_START: begin
        pos_d   = '0;
        acc_d   = '0;
        scl_d   = '0;
        goal_d  = SW'(total_i);
        k_d     = EW'(1);
        n_d     = (count_w < req_w) ? count_w[REQ_W-1:0] : req_i;
        first_d = 1'b1;
        lastb_d = '0;
        if (slot_free_i) begin
          emit_o.valid = 1'b1;
          emit_o.index = '0;
          emit_o.last  = 1'b0;
          em_d         = EW'(1);
          rd_en_o      = 1'b1;
          rd_addr_o    = '0;
          state_d      = (total_i == '0) ? WS_PAD : WS_DEC;
        end
      end
      WS_DEC: begin
        if (take) begin
          prod_d  = PW'(rd_data_i) * PW'(n_q);
          w_d     = rd_data_i;
          first_d = 1'b0;
          rd_en_o = 1'b1;  // prefetch the next weight
          state_d = WS_ADD;
        end else if (slot_free_i) begin
          // range k closes here; read data is held for the next range
          emit_o.valid = 1'b1;
          emit_o.index = BND_W'(pos_q);
          emit_o.last  = (em_q == req_e);
          em_d         = em_q + EW'(1);
          lastb_d      = pos_q;
          k_d          = k_inc;
          goal_d       = goal_q + SW'(total_i);
          first_d      = 1'b1;
          state_d      = more ? WS_DEC : WS_PAD;
        end
      end
      WS_ADD: begin
        scl_d   = scl_q + SW'(prod_q);
        acc_d   = acc_q + TW'(w_q);
        pos_d   = pos_inc;
        state_d = (pos_inc == item_count_i) ? WS_END : WS_DEC;
      end
      WS_END: begin
        if (slot_free_i) begin
          emit_o.valid = 1'b1;
          emit_o.index = BND_W'(pos_q);
          emit_o.last  = (em_q == req_e);
          em_d         = em_q + EW'(1);
          lastb_d      = pos_q;
          state_d      = WS_PAD;
        end
      end
      WS_PAD: begin
        if (em_q == req_p1) begin
          done_o  = 1'b1;
          state_d = WS_IDLE;
        end else if (slot_free_i) begin
          emit_o.valid = 1'b1;
          emit_o.index = BND_W'(lastb_q);
          emit_o.last  = (em_q == req_e);
          em_d         = em_q + EW'(1);
        end
      end
      default: begin
        state_d = WS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WS_IDLE;
      em_q    <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      em_q    <= em_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    acc_q   <= acc_d;
    scl_q   <= scl_d;
    goal_q  <= goal_d;
    k_q     <= k_d;
    n_q     <= n_d;
    prod_q  <= prod_d;
    w_q     <= w_d;
    lastb_q <= lastb_d;
  end

  a_emit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o.valid |-> slot_free_i)
    else $error("boundary sent while output register is full");

  a_dec_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == WS_DEC) |-> (pos_q < item_count_i))
    else $error("walk reads past the item count");

  a_done_after_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (em_q == req_p1) && (state_q == WS_PAD))
    else $error("run ends before all results are sent");

  a_em_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != WS_IDLE) && (state_q != WS_START) |-> (em_q <= req_p1))
    else $error("result count runs past the request");

endmodule

`default_nettype wire

>>> rtl/weighted_range_partitioner.sv
// Top level: list loader, weight store, partition walker and output register.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------
//  input    | in_valid_i / in_stall_o   | item_weight_i, last_item_i
//  output   | out_valid_o / out_stall_i | boundary_index_o, last_boundary_o, overflow_o
//  config   | cfg_we_i                  | cfg_wdata_i (range request)
//
// Loading accepts one item per cycle while the input is not stalled. After the last
// item the walk reads the weight store and does a scaled multiply-accumulate for each
// item it passes, and emits each range boundary and each padding result.
// The input is stalled from the last item until the final result has been handed to
// the output register. Output stalls pause the walk. The weight store is not cleared
// at reset; only entries below the item count are used.
`timescale 1ns / 1ps
`default_nettype none

module weighted_range_partitioner #(
  parameter int unsigned MAX_ITEMS   = wrp_pkg::MAX_ITEMS_DEF,
  parameter int unsigned WEIGHT_BITS = wrp_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [WEIGHT_BITS-1:0]       item_weight_i,
  input  wire logic                         last_item_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [wrp_pkg::BND_W-1:0]    boundary_index_o,
  output logic                              last_boundary_o,
  output logic                              overflow_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [wrp_pkg::REQ_W-1:0]    cfg_wdata_i
);

  import wrp_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned TW = WEIGHT_BITS + CW;

  logic [REQ_W-1:0] range_req_q;
  logic [REQ_W-1:0] req;
  logic [CW-1:0]    count_q;
  logic [TW-1:0]    total_q;
  logic             dropped_q;
  logic             busy_q;

  logic             in_acc, has_room, start;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [WEIGHT_BITS-1:0] rd_data;
  logic             slot_free, done;
  wrp_emit_t        emit;

  logic             out_valid_q;
  logic [BND_W-1:0] bnd_q;
  logic             last_q;
  logic             ovf_q;

  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign has_room   = (count_q < CW'(MAX_ITEMS));
  assign start      = in_acc && last_item_i;
  assign req        = (range_req_q == '0) ? REQ_W'(1) : range_req_q;
  assign slot_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_req_q <= REQ_RESET;
    end else if (cfg_we_i) begin
      range_req_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      total_q   <= '0;
      dropped_q <= 1'b0;
      busy_q    <= 1'b0;
    end else if (done) begin
      count_q   <= '0;
      total_q   <= '0;
      dropped_q <= 1'b0;
      busy_q    <= 1'b0;
    end else if (in_acc) begin
      if (has_room) begin
        count_q <= count_q + CW'(1);
        total_q <= total_q + TW'(item_weight_i);
      end else begin
        dropped_q <= 1'b1;
      end
      if (last_item_i) begin
        busy_q <= 1'b1;
      end
    end
  end

  wrp_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && has_room),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (item_weight_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  wrp_walk #(
    .MAX_ITEMS   (MAX_ITEMS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .item_count_i (count_q),
    .total_i      (total_q),
    .req_i        (req),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .slot_free_i  (slot_free),
    .emit_o       (emit),
    .done_o       (done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      bnd_q  <= emit.index;
      last_q <= emit.last;
      ovf_q  <= dropped_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign boundary_index_o = bnd_q;
  assign last_boundary_o  = last_q;
  assign overflow_o       = ovf_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ITEMS))
    else $error("item count beyond capacity");

  a_drop_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dropped_q |-> (count_q == CW'(MAX_ITEMS)))
    else $error("drop flag set with room left");

  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> (count_q != '0))
    else $error("walk started on an empty list");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for weighted_range_partitioner: predicted boundaries vs. DUT output.
module tb_top;
  import wrp_pkg::*;

  localparam int unsigned LIST_CAP     = MAX_ITEMS_DEF;
  localparam int unsigned MAX_CUTS     = 64;
  localparam int          HOLD_CYCLES  = 250;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          MAX_PRINTED  = 40;

  typedef enum int {MIX_FULL, MIX_SPARSE, MIX_HEAVY, MIX_EDGE} weight_mix_e;

  typedef struct {
    logic [BND_W-1:0] index;
    logic             last;
    logic             ovf;
  } boundary_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic [15:0]          item_weight_i = '0;
  logic                 last_item_i   = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic [BND_W-1:0]     boundary_index_o;
  logic                 last_boundary_o;
  logic                 overflow_o;
  logic                 cfg_we_i      = 1'b0;
  logic [REQ_W-1:0]     cfg_wdata_i   = '0;

  weighted_range_partitioner dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .item_weight_i    (item_weight_i),
    .last_item_i      (last_item_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .boundary_index_o (boundary_index_o),
    .last_boundary_o  (last_boundary_o),
    .overflow_o       (overflow_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: the list being loaded and the range request register
  logic [15:0]       list_weights [LIST_CAP];
  int unsigned       list_len     = 0;
  longint unsigned   list_sum     = 0;
  bit                list_dropped = 1'b0;
  logic [REQ_W-1:0]  ranges_cfg   = REQ_RESET;
  boundary_t         boundary_q [$];

  int  mismatches         = 0;
  int  items_sent         = 0;
  int  lists_sent         = 0;
  int  boundaries_checked = 0;
  int  configs_written    = 0;
  bit  sender_idle_on     = 1'b1;
  bit  receiver_idle_on   = 1'b1;
  int  hold_left          = 0;
  int  stall_burst        = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // cut the loaded list into ranges of about equal weight, queue the boundaries
  function automatic void partition_list();
    int unsigned     req, n, used, k, pos;
    int unsigned     cut [MAX_CUTS];
    longint unsigned acc, goal;
    boundary_t       b;
    req  = (ranges_cfg == 0) ? 1 : ranges_cfg;
    n    = (req < list_len) ? req : list_len;
    cut[0] = 0;
    used = 1;
    acc  = 0;
    k    = 1;
    while (acc < list_sum && k <= n && cut[k-1] < list_len) begin
      goal = (longint'(k) * list_sum) / n;
      pos  = cut[k-1];
      acc += list_weights[pos];
      pos++;
      // zero-weight items right after the goal still join this range
      while (pos < list_len && (acc < goal || list_weights[pos] == 0)) begin
        acc += list_weights[pos];
        pos++;
      end
      cut[k] = pos;
      used   = k + 1;
      k++;
    end
    for (int r = 0; r <= req; r++) begin
      b.index = BND_W'((r < used) ? cut[r] : cut[used-1]);
      b.last  = (r == req);
      b.ovf   = list_dropped;
      boundary_q.insert(boundary_q.size(), b);
    end
    list_len     = 0;
    list_sum     = 0;
    list_dropped = 1'b0;
  endfunction

  function automatic void load_item(input logic [15:0] w, input logic last);
    if (list_len < LIST_CAP) begin
      list_weights[list_len] = w;
      list_len++;
      list_sum += w;
    end else begin
      list_dropped = 1'b1;
    end
    items_sent++;
    if (last) begin
      lists_sent++;
      partition_list();
    end
  endfunction

  function automatic logic [15:0] pick_weight(input weight_mix_e mix);
    logic [15:0] w;
    case (mix)
      MIX_FULL:   w = 16'($urandom_range(0, 65535));
      MIX_SPARSE: w = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(0, 15));
      MIX_HEAVY:  w = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      default: begin
        case ($urandom_range(0, 3))
          0:       w = 16'd0;
          1:       w = 16'd1;
          2:       w = 16'hFFFF;
          default: w = 16'($urandom_range(0, 65535));
        endcase
      end
    endcase
    return w;
  endfunction

  // one request on the input channel; returns at the falling edge after acceptance
  task automatic send_item(input logic [15:0] w, input logic last);
    int gap;
    if (sender_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    item_weight_i = w;
    last_item_i   = last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    load_item(w, last);
    @(negedge clk_i);
  endtask

  task automatic send_list(input int len, input weight_mix_e mix);
    for (int i = 0; i < len; i++) send_item(pick_weight(mix), i == len - 1);
  endtask

  task automatic wait_drain();
    in_valid_i = 1'b0;
    while (boundary_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_ranges(input logic [REQ_W-1:0] value);
    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    ranges_cfg  = value;
    configs_written++;
  endtask

  // receiver: long hold-off when requested, otherwise random stall bursts
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (stall_burst > 0) begin
        out_stall_i = 1'b1;
        stall_burst--;
      end else if (receiver_idle_on && $urandom_range(0, 4) == 0) begin
        out_stall_i = 1'b1;
        stall_burst = $urandom_range(0, 10);
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_boundaries
    boundary_t exp_b;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (boundary_q.size() == 0) begin
        report_mismatch($sformatf("boundary %0d with nothing expected", boundary_index_o));
      end else begin
        exp_b = boundary_q[0];
        boundary_q.delete(0);
        if (boundary_index_o !== exp_b.index)
          report_mismatch($sformatf("boundary_index %0d, expected %0d",
                                    boundary_index_o, exp_b.index));
        if (last_boundary_o !== exp_b.last)
          report_mismatch($sformatf("last_boundary %b, expected %b",
                                    last_boundary_o, exp_b.last));
        if (overflow_o !== exp_b.ovf)
          report_mismatch($sformatf("overflow %b, expected %b", overflow_o, exp_b.ovf));
        boundaries_checked++;
      end
    end
  end

  // one full-scale item under the reset range request
  task automatic test_single_heavy_item();
    send_item(16'hFFFF, 1'b1);
  endtask

  task automatic test_zero_weights();
    send_item(16'd0, 1'b0);
    send_item(16'd0, 1'b0);
    send_item(16'd0, 1'b1);
    write_ranges(6'd2);
    send_item(16'd5, 1'b0);
    send_item(16'd0, 1'b0);
    send_item(16'd0, 1'b0);
    send_item(16'd5, 1'b0);
    send_item(16'd0, 1'b1);
  endtask

  task automatic test_range_extremes();
    write_ranges(6'd0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'd1, 1'b1);
    write_ranges(6'd63);
    send_list(6, MIX_EDGE);
    write_ranges(6'd1);
    send_item(16'd0, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'd0, 1'b1);
  endtask

  // two items past the store size, the last of them the list end
  task automatic test_capacity_overflow();
    write_ranges(6'd8);
    send_list(LIST_CAP + 2, MIX_FULL);
    send_list(3, MIX_FULL);
  endtask

  task automatic test_output_holdoff();
    wait_drain();
    @(posedge clk_i);
    hold_left = HOLD_CYCLES;
    @(negedge clk_i);
    send_list(10, MIX_HEAVY);
    send_list(12, MIX_EDGE);
    wait_drain();
  endtask

  task automatic test_random_lists(input int item_goal, input bit with_idle);
    int          start, len;
    weight_mix_e mix;
    start = items_sent;
    while (items_sent - start < item_goal) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       write_ranges(6'd63);
          1:       write_ranges(6'd1);
          default: write_ranges(REQ_W'($urandom_range(0, 63)));
        endcase
      end
      sender_idle_on   = with_idle && ($urandom_range(0, 3) != 0);
      receiver_idle_on = with_idle && ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 20);
      mix = weight_mix_e'($urandom_range(0, 3));
      send_list(len, mix);
      if ($urandom_range(0, 5) == 0) wait_drain();
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_single_heavy_item();
    test_zero_weights();
    test_range_extremes();
    test_capacity_overflow();
    test_output_holdoff();
    test_random_lists(250, 1'b1);
    test_random_lists(60, 1'b0);

    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("covered %0d lists, %0d items, %0d range settings incl. 0, 1, 63 and overflow",
             lists_sent, items_sent, configs_written);
    $display("%0d boundaries checked, %0d mismatches", boundaries_checked, mismatches);
    if (mismatches == 0) begin
      $display("weighted_range_partitioner regression: pass");
    end else begin
      $display("weighted_range_partitioner regression: fail");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("timeout with %0d boundaries outstanding", boundary_q.size());
    $display("weighted_range_partitioner regression: fail");
    $finish;
  end

endmodule

>>> files.f
rtl/wrp_pkg.sv
rtl/wrp_ram.sv
rtl/wrp_walk.sv
rtl/weighted_range_partitioner.sv
tb/tb_top.sv
